/* design/rcc_pkg.sv */
// ----------------------------------------------------------------------------
// rcc_pkg: shared constants for the reset and clock controller register unit
// Register offsets, reset values, field masks and sequencer records.
// ----------------------------------------------------------------------------
`default_nettype none
package rcc_pkg;
    localparam logic [31:0] BASE_ADDRESS_DEF = 32'd1073887232;
    localparam logic [31:0] HSI_RATE_DEF     = 32'd16000000;
    localparam logic [31:0] HSE_RATE_DEF     = 32'd8000000;

    localparam logic [31:0] CR_RESET    = 32'h0000_0083;
    localparam logic [31:0] PLLCFG_RESET = 32'h2400_3010;
    localparam logic [31:0] CSR_RESET   = 32'h0E00_0000;
    localparam logic [31:0] PLLI2S_RESET = 32'h2000_3000;
    localparam logic [31:0] CSR_KEEP    = 32'hFF00_0000;
    localparam logic [31:0] CSR_WRITE   = 32'h00FF_FFFF;

    localparam int NBANK = 5;

    // register select codes
    localparam logic [4:0] SEL_NONE   = 5'd0;
    localparam logic [4:0] SEL_CR     = 5'd1;
    localparam logic [4:0] SEL_PLL    = 5'd2;
    localparam logic [4:0] SEL_CFGR   = 5'd3;
    localparam logic [4:0] SEL_CIR    = 5'd4;
    localparam logic [4:0] SEL_BDCR   = 5'd5;
    localparam logic [4:0] SEL_CSR    = 5'd6;
    localparam logic [4:0] SEL_SSCG   = 5'd7;
    localparam logic [4:0] SEL_I2S    = 5'd8;
    localparam logic [4:0] SEL_RST0   = 5'd9;
    localparam logic [4:0] SEL_EN0    = 5'd14;
    localparam logic [4:0] SEL_LP0    = 5'd19;

    // divider handshake between sequencer and the shared divider
    typedef struct packed {
        logic        start;
        logic [35:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } t_div_rsp;

    function automatic logic [4:0] decode(input logic [31:0] off);
        logic [4:0] s;
        s = SEL_NONE;
        unique case (off)
            32'h00: s = SEL_CR;
            32'h04: s = SEL_PLL;
            32'h08: s = SEL_CFGR;
            32'h0C: s = SEL_CIR;
            32'h70: s = SEL_BDCR;
            32'h74: s = SEL_CSR;
            32'h80: s = SEL_SSCG;
            32'h84: s = SEL_I2S;
            32'h10: s = SEL_RST0;
            32'h14: s = SEL_RST0 + 5'd1;
            32'h18: s = SEL_RST0 + 5'd2;
            32'h20: s = SEL_RST0 + 5'd3;
            32'h24: s = SEL_RST0 + 5'd4;
            32'h30: s = SEL_EN0;
            32'h34: s = SEL_EN0 + 5'd1;
            32'h38: s = SEL_EN0 + 5'd2;
            32'h40: s = SEL_EN0 + 5'd3;
            32'h44: s = SEL_EN0 + 5'd4;
            32'h50: s = SEL_LP0;
            32'h54: s = SEL_LP0 + 5'd1;
            32'h58: s = SEL_LP0 + 5'd2;
            32'h60: s = SEL_LP0 + 5'd3;
            32'h64: s = SEL_LP0 + 5'd4;
            default: s = SEL_NONE;
        endcase
        return s;
    endfunction

    // log2 of the AHB divider for prescaler codes 8..15
    function automatic logic [3:0] ahb_shift(input logic [3:0] hpre);
        logic [3:0] r;
        unique case (hpre)
            4'd8:  r = 4'd1;
            4'd9:  r = 4'd2;
            4'd10: r = 4'd3;
            4'd11: r = 4'd4;
            4'd12: r = 4'd6;
            4'd13: r = 4'd7;
            4'd14: r = 4'd8;
            4'd15: r = 4'd9;
            default: r = 4'd0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

/* design/rcc_divider.sv */
// ----------------------------------------------------------------------------
// rcc_divider: shared radix-2 restoring divider
// Unsigned 36 by 32 divide, one quotient bit per cycle, low 32 quotient bits out.
// ----------------------------------------------------------------------------
`default_nettype none
module rcc_divider (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rcc_pkg::t_div_req i_req,
    output rcc_pkg::t_div_rsp      o_rsp
);
    import rcc_pkg::*;

    logic [31:0] r_rem, n_rem;
    logic [35:0] r_quo, n_quo;
    logic [31:0] r_den, n_den;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [32:0] trial;

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        trial  = {r_rem, r_quo[35]} - {1'b0, r_den};
        if (i_req.start) begin
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_den  = i_req.divisor;
            n_cnt  = 6'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            // shift in next dividend bit, subtract when it fits
            if (!trial[32]) begin
                n_rem = trial[31:0];
                n_quo = {r_quo[34:0], 1'b1};
            end else begin
                n_rem = {r_rem[30:0], r_quo[35]};
                n_quo = {r_quo[34:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd35) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo[31:0];
endmodule
`default_nettype wire

/* design/reset_clock_controller_regs_unit.sv */
// ----------------------------------------------------------------------------
// reset_clock_controller_regs_unit: RCC register file with clock rate engine
// Decodes bus accesses, applies write side effects and derives bus clocks.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------
//  access   | i_start / o_busy       | i_action, i_address, i_write_data
//  result   | o_valid (one cycle)    | o_read_data, clock rates, masks
//
//  An access with sysclk on HSI or HSE steps through IDLE, RATE and OUT. With
//  the PLL selected the shared serial divider computes src / M (36 quotient
//  bits, then the done handoff); for P of 2, 4 or 8 the product is shifted, and P
//  of 6 runs the divider a second time on (src / M) * N.
//  Prescaler divides are powers of two and done as shifts.
//  Reset is synchronous, active low, and restores every mapped register value.
//  The result strobe lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
`default_nettype none
module reset_clock_controller_regs_unit #(
    parameter logic [31:0] BASE_ADDRESS = rcc_pkg::BASE_ADDRESS_DEF,
    parameter logic [31:0] HSI_RATE_HZ  = rcc_pkg::HSI_RATE_DEF,
    parameter logic [31:0] HSE_RATE_HZ  = rcc_pkg::HSE_RATE_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic        i_action,
    input  wire logic [31:0] i_address,
    input  wire logic [31:0] i_write_data,
    output logic             o_valid,
    output logic [31:0]      o_read_data,
    output logic [31:0]      o_sysclk_hz,
    output logic [31:0]      o_hclk_hz,
    output logic [31:0]      o_pclk1_hz,
    output logic [31:0]      o_pclk2_hz,
    output logic [31:0]      o_timclk1_hz,
    output logic [31:0]      o_timclk2_hz,
    output logic [10:0]      o_gpio_enable_mask,
    output logic [3:0]       o_usart_enable_mask,
    output logic [1:0]       o_timer_enable_mask,
    output logic [2:0]       o_misc_enable_mask
);
    import rcc_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RATE  = 3'd1;
    localparam logic [2:0] ST_DIVM  = 3'd2;
    localparam logic [2:0] ST_MULN  = 3'd3;
    localparam logic [2:0] ST_DIVP  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]  r_state;
    logic [31:0] r_cr, r_pll, r_cfgr, r_cir, r_bdcr, r_csr, r_sscg, r_i2s;
    logic [31:0] r_rst [NBANK];
    logic [31:0] r_en  [NBANK];
    logic [31:0] r_lp  [NBANK];
    logic [31:0] r_rd;
    logic [31:0] r_sys;
    logic [31:0] r_tmp;
    logic        r_valid;

    t_div_req div_req;
    t_div_rsp div_rsp;

    rcc_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // ---- access decode ----
    logic [4:0]  sel;
    logic [31:0] rd_val;
    assign sel = decode(i_address - BASE_ADDRESS);

    always_comb begin
        rd_val = '0;
        if (sel == SEL_CR)        rd_val = r_cr;
        else if (sel == SEL_PLL)  rd_val = r_pll;
        else if (sel == SEL_CFGR) rd_val = r_cfgr;
        else if (sel == SEL_CIR)  rd_val = r_cir;
        else if (sel == SEL_BDCR) rd_val = r_bdcr;
        else if (sel == SEL_CSR)  rd_val = r_csr;
        else if (sel == SEL_SSCG) rd_val = r_sscg;
        else if (sel == SEL_I2S)  rd_val = r_i2s;
        for (int k = 0; k < NBANK; k++) begin
            if (sel == SEL_RST0 + 5'(k)) rd_val = r_rst[k];
            if (sel == SEL_EN0 + 5'(k))  rd_val = r_en[k];
            if (sel == SEL_LP0 + 5'(k))  rd_val = r_lp[k];
        end
    end

    // control register: each ready bit follows its enable bit
    function automatic logic [31:0] cr_mirror(input logic [31:0] v);
        logic [31:0] r;
        r = v;
        r[1]  = v[0];
        r[17] = v[16];
        r[25] = v[24];
        r[27] = v[26];
        return r;
    endfunction

    logic [31:0] csr_mix;
    assign csr_mix = (r_csr & CSR_KEEP) | (i_write_data & CSR_WRITE);

    // ---- PLL operands ----
    logic [31:0] pll_src, pll_m, pll_n, pll_p;
    assign pll_src = r_pll[22] ? HSE_RATE_HZ : HSI_RATE_HZ;
    assign pll_m   = (r_pll[5:0] == 6'd0) ? 32'd2 : {26'd0, r_pll[5:0]};
    assign pll_n   = (r_pll[14:6] == 9'd0) ? 32'd1 : {23'd0, r_pll[14:6]};
    assign pll_p   = {28'd0, ({1'b0, r_pll[17:16]} + 3'd1), 1'b0};

    // src/M < 2^27 and N < 2^9, so the product stays under 2^36
    logic [35:0] prod;
    assign prod = 36'(r_tmp) * 36'(pll_n);

    always_comb begin
        div_req = '0;
        if (r_state == ST_RATE && r_cfgr[3]) begin
            div_req.start    = 1'b1;
            div_req.dividend = {4'd0, pll_src};
            div_req.divisor  = pll_m;
        end else if (r_state == ST_MULN && r_pll[17:16] == 2'd2) begin
            div_req.start    = 1'b1;
            div_req.dividend = prod;
            div_req.divisor  = pll_p;
        end
    end

    // P in {2,4,8}: shift the full product; P of 6 goes through the divider
    // on the full 36-bit product. Keep the low 32 bits of the quotient.
    logic [31:0] rate_div;
    logic [34:0] half;
    assign half = prod[35:1];
    always_comb begin
        unique case (r_pll[17:16])
            2'd0: rate_div = half[31:0];
            2'd1: rate_div = half[32:1];
            2'd3: rate_div = half[33:2];
            default: rate_div = 32'd0;
        endcase
    end

    // ---- prescalers ----
    logic [31:0] hclk, pclk1, pclk2;
    logic [2:0]  ppre1, ppre2;
    logic [2:0]  sh1, sh2;
    assign hclk  = r_cfgr[7] ? (r_sys >> ahb_shift(r_cfgr[7:4])) : r_sys;
    assign ppre1 = r_cfgr[12:10];
    assign ppre2 = r_cfgr[15:13];
    assign sh1   = ppre1[2] ? ({1'b0, ppre1[1:0]} + 3'd1) : 3'd0;
    assign sh2   = ppre2[2] ? ({1'b0, ppre2[1:0]} + 3'd1) : 3'd0;
    assign pclk1 = ppre1[2] ? (hclk >> sh1) : hclk;
    assign pclk2 = ppre2[2] ? (hclk >> sh2) : hclk;

    // ---- sequencer ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_cr    <= CR_RESET;
            r_pll   <= PLLCFG_RESET;
            r_cfgr  <= '0;
            r_cir   <= '0;
            r_bdcr  <= '0;
            r_csr   <= CSR_RESET;
            r_sscg  <= '0;
            r_i2s   <= PLLI2S_RESET;
            for (int k = 0; k < NBANK; k++) begin
                r_rst[k] <= '0;
                r_en[k]  <= '0;
                r_lp[k]  <= '0;
            end
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_rd    <= i_action ? 32'd0 : rd_val;
                        r_state <= ST_RATE;
                        if (i_action) begin
                            if (sel == SEL_CR)   r_cr <= cr_mirror(i_write_data);
                            if (sel == SEL_PLL)  r_pll <= i_write_data;
                            if (sel == SEL_CFGR) r_cfgr <= {i_write_data[31:4],
                                                  i_write_data[1:0], i_write_data[1:0]};
                            if (sel == SEL_CIR)  r_cir <= r_cir & ~i_write_data;
                            if (sel == SEL_BDCR) r_bdcr <= i_write_data |
                                                  {30'd0, i_write_data[0], 1'b0};
                            if (sel == SEL_CSR)  r_csr <= csr_mix |
                                                  {30'd0, csr_mix[0], 1'b0};
                            if (sel == SEL_SSCG) r_sscg <= i_write_data;
                            if (sel == SEL_I2S)  r_i2s <= i_write_data;
                            for (int k = 0; k < NBANK; k++) begin
                                if (sel == SEL_RST0 + 5'(k)) r_rst[k] <= i_write_data;
                                if (sel == SEL_EN0 + 5'(k))  r_en[k]  <= i_write_data;
                                if (sel == SEL_LP0 + 5'(k))  r_lp[k]  <= i_write_data;
                            end
                        end
                    end
                end
                ST_RATE: begin
                    // select source; PLL path launches src / M
                    if (r_cfgr[3]) begin
                        r_state <= ST_DIVM;
                    end else begin
                        r_sys   <= r_cfgr[2] ? HSE_RATE_HZ : HSI_RATE_HZ;
                        r_state <= ST_OUT;
                    end
                end
                ST_DIVM: begin
                    if (div_rsp.done) begin
                        r_tmp   <= div_rsp.quotient;
                        r_state <= ST_MULN;
                    end
                end
                ST_MULN: begin
                    // P of 6 needs the divider; others are shifts
                    if (r_pll[17:16] == 2'd2) begin
                        r_state <= ST_DIVP;
                    end else begin
                        r_sys   <= rate_div;
                        r_state <= ST_OUT;
                    end
                end
                ST_DIVP: begin
                    if (div_rsp.done) begin
                        r_sys   <= div_rsp.quotient;
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    r_valid <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // ---- result registers ----
    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT) begin
            o_read_data  <= r_rd;
            o_sysclk_hz  <= r_sys;
            o_hclk_hz    <= hclk;
            o_pclk1_hz   <= pclk1;
            o_pclk2_hz   <= pclk2;
            o_timclk1_hz <= ppre1[2] ? {pclk1[30:0], 1'b0} : pclk1;
            o_timclk2_hz <= ppre2[2] ? {pclk2[30:0], 1'b0} : pclk2;
            o_gpio_enable_mask  <= r_en[0][10:0];
            o_usart_enable_mask <= {r_en[4][5], r_en[3][18], r_en[3][17], r_en[4][4]};
            o_timer_enable_mask <= r_en[3][1:0];
            o_misc_enable_mask  <= {r_en[3][21], r_en[4][12], r_en[4][8]};
        end
    end

    assign o_valid = r_valid;
    assign o_busy  = (r_state != ST_IDLE);

    // ---- checks ----
    a_valid_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |=> o_valid)
        else $error("result strobe missing");
    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted access did not raise busy");
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == ST_DIVM || r_state == ST_DIVP))
        else $error("divider finished outside a divide step");
endmodule
`default_nettype wire

/* tb/sv/reset_clock_controller_regs_unit_tb.sv */
// ----------------------------------------------------------------------------
// reset_clock_controller_regs_unit_tb: self-checking bench for the RCC unit
// Drives register reads and writes, predicts read data, clock rates and
// enable masks from a shadow register file, and checks every result.
// ----------------------------------------------------------------------------
`default_nettype none
module reset_clock_controller_regs_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rcc_pkg::*;

    localparam logic [31:0] HSI_HZ = HSI_RATE_DEF;
    localparam logic [31:0] HSE_HZ = HSE_RATE_DEF;
    localparam logic        ACC_READ  = 1'b0;
    localparam logic        ACC_WRITE = 1'b1;
    localparam int          N_RANDOM  = 2000;
    localparam longint      CYCLE_LIMIT = 2000000;

    // one bus access
    typedef struct packed {
        logic        action;
        logic [31:0] address;
        logic [31:0] wdata;
    } t_access;

    // one result transfer
    typedef struct packed {
        logic [31:0] rdata;
        logic [31:0] sys;
        logic [31:0] hclk;
        logic [31:0] p1;
        logic [31:0] p2;
        logic [31:0] t1;
        logic [31:0] t2;
        logic [10:0] gpio;
        logic [3:0]  usart;
        logic [1:0]  timer;
        logic [2:0]  misc;
    } t_rates;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        i_action = 1'b0;
    logic [31:0] i_address = '0;
    logic [31:0] i_write_data = '0;
    logic        o_busy, o_valid;
    logic [31:0] o_read_data, o_sysclk_hz, o_hclk_hz, o_pclk1_hz, o_pclk2_hz;
    logic [31:0] o_timclk1_hz, o_timclk2_hz;
    logic [10:0] o_gpio_enable_mask;
    logic [3:0]  o_usart_enable_mask;
    logic [1:0]  o_timer_enable_mask;
    logic [2:0]  o_misc_enable_mask;

    reset_clock_controller_regs_unit uut (.*);

    always #5 i_clk = ~i_clk;

    // shadow register file
    logic [31:0] sh_cr, sh_pll, sh_cfgr, sh_cir, sh_bdcr, sh_csr, sh_sscg, sh_i2s;
    logic [31:0] sh_rst [NBANK];
    logic [31:0] sh_en  [NBANK];
    logic [31:0] sh_lp  [NBANK];

    t_access pending_accesses[$];
    t_rates  expected_rates[$];
    int      errors = 0;
    int      n_results = 0;
    int      n_writes = 0;
    bit      stim_done = 0;
    longint  cycles = 0;

    function automatic void shadow_reset();
        sh_cr = CR_RESET; sh_pll = PLLCFG_RESET; sh_cfgr = '0; sh_cir = '0;
        sh_bdcr = '0; sh_csr = CSR_RESET; sh_sscg = '0; sh_i2s = PLLI2S_RESET;
        for (int i = 0; i < NBANK; i++) begin
            sh_rst[i] = '0; sh_en[i] = '0; sh_lp[i] = '0;
        end
    endfunction

    function automatic logic [31:0] follow(logic [31:0] v, int en, int rdy);
        logic [31:0] r;
        r = v;
        r[rdy] = v[en];
        return r;
    endfunction

    function automatic int bank_index(logic [31:0] off, logic [31:0] base);
        logic [31:0] rel;
        rel = off - base;
        case (rel)
            32'h00: return 0;
            32'h04: return 1;
            32'h08: return 2;
            32'h10: return 3;
            32'h14: return 4;
            default: return -1;
        endcase
    endfunction

    function automatic logic [31:0] pll_rate();
        logic [63:0] src, m, n, p;
        src = sh_pll[22] ? HSE_HZ : HSI_HZ;
        m = sh_pll[5:0];
        n = sh_pll[14:6];
        p = (sh_pll[17:16] + 64'd1) * 2;
        if (m == 0) m = 2;
        if (n == 0) n = 1;
        return 32'(((src / m) * n) / p);
    endfunction

    function automatic logic [31:0] apb_divisor(logic [2:0] f);
        return (f < 4) ? 32'd1 : (32'd1 << (f - 3));
    endfunction

    // apply one access to the shadow and return the expected result
    function automatic t_rates predict_access(t_access a);
        t_rates r;
        logic [31:0] off, v, d1, d2, apb1, apb2;
        logic [3:0]  hpre;
        int          bi;
        off = a.address - BASE_ADDRESS_DEF;
        r = '0;
        if (a.action == ACC_READ) begin
            case (off)
                32'h00: r.rdata = sh_cr;
                32'h04: r.rdata = sh_pll;
                32'h08: r.rdata = sh_cfgr;
                32'h0C: r.rdata = sh_cir;
                32'h70: r.rdata = sh_bdcr;
                32'h74: r.rdata = sh_csr;
                32'h80: r.rdata = sh_sscg;
                32'h84: r.rdata = sh_i2s;
                default: begin
                    if ((bi = bank_index(off, 32'h10)) >= 0) r.rdata = sh_rst[bi];
                    else if ((bi = bank_index(off, 32'h30)) >= 0) r.rdata = sh_en[bi];
                    else if ((bi = bank_index(off, 32'h50)) >= 0) r.rdata = sh_lp[bi];
                end
            endcase
        end else begin
            case (off)
                32'h00: begin
                    v = follow(a.wdata, 0, 1);
                    v = follow(v, 16, 17);
                    v = follow(v, 24, 25);
                    sh_cr = follow(v, 26, 27);
                end
                32'h04: sh_pll = a.wdata;
                32'h08: sh_cfgr = {a.wdata[31:4], a.wdata[1:0], a.wdata[1:0]};
                32'h0C: sh_cir = sh_cir & ~a.wdata;
                32'h70: sh_bdcr = a.wdata | {30'd0, a.wdata[0], 1'b0};
                32'h74: begin
                    v = (sh_csr & CSR_KEEP) | (a.wdata & CSR_WRITE);
                    sh_csr = v | {30'd0, v[0], 1'b0};
                end
                32'h80: sh_sscg = a.wdata;
                32'h84: sh_i2s = a.wdata;
                default: begin
                    if ((bi = bank_index(off, 32'h10)) >= 0) sh_rst[bi] = a.wdata;
                    else if ((bi = bank_index(off, 32'h30)) >= 0) sh_en[bi] = a.wdata;
                    else if ((bi = bank_index(off, 32'h50)) >= 0) sh_lp[bi] = a.wdata;
                end
            endcase
        end
        case (sh_cfgr[3:2])
            2'd0: r.sys = HSI_HZ;
            2'd1: r.sys = HSE_HZ;
            default: r.sys = pll_rate();   // both upper codes pick the PLL
        endcase
        hpre = sh_cfgr[7:4];
        r.hclk = hpre[3] ? (r.sys >> ahb_shift(hpre)) : r.sys;
        d1 = apb_divisor(sh_cfgr[12:10]);
        d2 = apb_divisor(sh_cfgr[15:13]);
        r.p1 = r.hclk / d1;
        r.p2 = r.hclk / d2;
        r.t1 = (d1 == 1) ? r.p1 : r.p1 << 1;
        r.t2 = (d2 == 1) ? r.p2 : r.p2 << 1;
        apb1 = sh_en[3];
        apb2 = sh_en[4];
        r.gpio  = sh_en[0][10:0];
        r.usart = {apb2[5], apb1[18], apb1[17], apb2[4]};
        r.timer = apb1[1:0];
        r.misc  = {apb1[21], apb2[12], apb2[8]};
        return r;
    endfunction

    // offsets of every mapped register, for address picks
    logic [31:0] mapped_offs [23] = '{32'h00, 32'h04, 32'h08, 32'h0C, 32'h10,
        32'h14, 32'h18, 32'h20, 32'h24, 32'h30, 32'h34, 32'h38, 32'h40, 32'h44,
        32'h50, 32'h54, 32'h58, 32'h60, 32'h64, 32'h70, 32'h74, 32'h80, 32'h84};

    function automatic t_access make_access(logic act, logic [31:0] off, logic [31:0] d);
        t_access a;
        a.action = act;
        a.address = BASE_ADDRESS_DEF + off;
        a.wdata = d;
        return a;
    endfunction

    // random but plausible clock-config value: favour active AHB prescaler codes
    function automatic logic [31:0] random_cfgr();
        logic [31:0] v;
        v = $urandom;
        if ($urandom_range(0, 3) == 0) v[7:4] = 4'(8 + $urandom_range(0, 7));
        return v;
    endfunction

    initial begin
        logic [31:0] off, d;
        int          k;
        shadow_reset();
        // directed: reads of reset values, extremes, every side effect
        foreach (mapped_offs[i]) pending_accesses.push_back(make_access(ACC_READ, mapped_offs[i], '0));
        pending_accesses.push_back(make_access(ACC_WRITE, 32'h00, 32'h0505_0001));
        pending_accesses.push_back(make_access(ACC_WRITE, 32'h00, 32'hFAFA_FFFE));
        pending_accesses.push_back(make_access(ACC_READ, 32'h00, '0));
        pending_accesses.push_back(make_access(ACC_WRITE, 32'h04, 32'h0000_0000));  // zero M, N
        pending_accesses.push_back(make_access(ACC_WRITE, 32'h08, 32'hFFFF_FFFE));  // PLL, max divs
        pending_accesses.push_back(make_access(ACC_WRITE, 32'h04, 32'hFFFF_FFFF));
        pending_accesses.push_back(make_access(ACC_WRITE, 32'h04, 32'h0040_7FC1));  // huge N
        pending_accesses.push_back(make_access(ACC_WRITE, 32'h08, 32'h0000_2493));  // code 3 => PLL
        pending_accesses.push_back(make_access(ACC_WRITE, 32'h0C, 32'hFFFF_FFFF));
        pending_accesses.push_back(make_access(ACC_WRITE, 32'h70, 32'h0000_0001));
        pending_accesses.push_back(make_access(ACC_WRITE, 32'h74, 32'hFFFF_FFFF));
        pending_accesses.push_back(make_access(ACC_READ, 32'h74, '0));
        pending_accesses.push_back(make_access(ACC_WRITE, 32'h40, 32'hFFFF_FFFF));
        pending_accesses.push_back(make_access(ACC_WRITE, 32'h44, 32'hFFFF_FFFF));
        pending_accesses.push_back(make_access(ACC_WRITE, 32'h30, 32'hFFFF_FFFF));
        pending_accesses.push_back(make_access(ACC_WRITE, 32'h02, 32'hFFFF_FFFF));  // unaligned
        pending_accesses.push_back(make_access(ACC_READ, 32'h1C, '0));               // hole
        pending_accesses.push_back(make_access(ACC_READ, 32'hFFFF_FFFC, '0));        // below base
        pending_accesses.push_back(make_access(ACC_WRITE, 32'h08, 32'h0000_0000));
        // random part: mostly mapped offsets, some raw addresses
        for (k = 0; k < N_RANDOM; k++) begin
            case ($urandom_range(0, 9))
                0: off = $urandom - BASE_ADDRESS_DEF;
                1: off = 32'($urandom_range(0, 255));
                default: off = mapped_offs[$urandom_range(0, 22)];
            endcase
            d = $urandom;
            if (off == 32'h08) d = random_cfgr();
            if (off == 32'h04 && $urandom_range(0, 1)) d[5:0] = 6'($urandom_range(0, 3));
            pending_accesses.push_back(make_access(1'($urandom), off, d));
        end
    end

    // driver: bursts of back-to-back starts separated by idle gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n || (i_start && o_busy)) begin
            // hold the current request until it is taken
        end else if (pending_accesses.size() == 0) begin
            i_start <= 1'b0;
            stim_done <= 1'b1;
        end else if (gap_left > 0) begin
            i_start <= 1'b0;
            gap_left <= gap_left - 1;
        end else begin
            i_start      <= 1'b1;
            i_action     <= pending_accesses[0].action;
            i_address    <= pending_accesses[0].address;
            i_write_data <= pending_accesses[0].wdata;
            if (burst_left == 0) begin
                burst_left <= $urandom_range(1, 12);
                gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            end else begin
                burst_left <= burst_left - 1;
            end
        end
    end

    // predict on the accepting edge; remove the access from the queue
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && i_start && !o_busy) begin
            expected_rates.push_back(predict_access(pending_accesses.pop_front()));
            if (i_action == ACC_WRITE) n_writes <= n_writes + 1;
        end
    end

    // monitor: compare each strobed result against the oldest expectation
    always @(posedge i_clk) begin
        t_rates e;
        if (i_rst_n && o_valid) begin
            if (expected_rates.size() == 0) begin
                $error("result with no pending access");
                errors = errors + 1;
            end else begin
                e = expected_rates.pop_front();
                n_results <= n_results + 1;
                if (o_read_data !== e.rdata) begin
                    $error("read_data exp %h got %h", e.rdata, o_read_data); errors = errors + 1; end
                if (o_sysclk_hz !== e.sys) begin
                    $error("sysclk_hz exp %0d got %0d", e.sys, o_sysclk_hz); errors = errors + 1; end
                if (o_hclk_hz !== e.hclk) begin
                    $error("hclk_hz exp %0d got %0d", e.hclk, o_hclk_hz); errors = errors + 1; end
                if (o_pclk1_hz !== e.p1) begin
                    $error("pclk1_hz exp %0d got %0d", e.p1, o_pclk1_hz); errors = errors + 1; end
                if (o_pclk2_hz !== e.p2) begin
                    $error("pclk2_hz exp %0d got %0d", e.p2, o_pclk2_hz); errors = errors + 1; end
                if (o_timclk1_hz !== e.t1) begin
                    $error("timclk1_hz exp %0d got %0d", e.t1, o_timclk1_hz); errors = errors + 1; end
                if (o_timclk2_hz !== e.t2) begin
                    $error("timclk2_hz exp %0d got %0d", e.t2, o_timclk2_hz); errors = errors + 1; end
                if (o_gpio_enable_mask !== e.gpio) begin
                    $error("gpio_enable_mask exp %h got %h", e.gpio, o_gpio_enable_mask);
                    errors = errors + 1; end
                if (o_usart_enable_mask !== e.usart) begin
                    $error("usart_enable_mask exp %h got %h", e.usart, o_usart_enable_mask);
                    errors = errors + 1; end
                if (o_timer_enable_mask !== e.timer) begin
                    $error("timer_enable_mask exp %h got %h", e.timer, o_timer_enable_mask);
                    errors = errors + 1; end
                if (o_misc_enable_mask !== e.misc) begin
                    $error("misc_enable_mask exp %h got %h", e.misc, o_misc_enable_mask);
                    errors = errors + 1; end
            end
        end
    end

    // reset, then wait for the queues to drain and a tail of idle cycles
    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
        wait (stim_done && expected_rates.size() == 0);
        repeat (100) @(posedge i_clk);
        $display("Covered %0d transfers (%0d writes) over %0d cycles.",
                 n_results, n_writes, cycles);
        if (errors == 0 && expected_rates.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog
    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("Timed out with %0d results pending.", expected_rates.size());
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
`default_nettype wire
